>>> design/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define ASSERT_AT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// property checked on every clock edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> design/hsv_pkg.sv
// types, widths and divider step functions for the rgb to hsv pixel converter
`timescale 1ns / 1ps

package hsv_pkg;

  localparam int unsigned ChanW    = 8;
  localparam int unsigned HueW     = 9;
  localparam int unsigned SatW     = 8;
  localparam int unsigned ValW     = 8;
  // quotient bits, one divider cell per bit
  localparam int unsigned QuoW     = 9;
  localparam int unsigned DsrShift = QuoW - 1;
  // exact hue times delta, below 360 * 255
  localparam int unsigned HueNumW  = 17;
  // hue dividend up to 255 * 360 * 255, divisor up to 360 * 255 shifted by DsrShift
  localparam int unsigned HueDivW  = 25;
  // saturation and value dividends below 2^16, divisors up to 510 shifted by DsrShift
  localparam int unsigned SvDivW   = 17;
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 32;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_e;

  typedef struct packed {
    logic [HueDivW-1:0] rem;
    logic [HueDivW-1:0] dsr;
    logic [QuoW-1:0]    quo;
  } hue_lane_t;

  typedef struct packed {
    logic [SvDivW-1:0] rem;
    logic [SvDivW-1:0] dsr;
    logic [QuoW-1:0]   quo;
  } sv_lane_t;

  typedef struct packed {
    hue_lane_t hue;
    sv_lane_t  sat;
    sv_lane_t  val;
  } div_word_t;

  function automatic hue_lane_t hue_step(hue_lane_t l);
    hue_lane_t r;
    r = l;
    if (l.rem >= l.dsr) begin
      r.rem = l.rem - l.dsr;
      r.quo = {l.quo[QuoW-2:0], 1'b1};
    end else begin
      r.quo = {l.quo[QuoW-2:0], 1'b0};
    end
    r.dsr = l.dsr >> 1;
    return r;
  endfunction

  function automatic sv_lane_t sv_step(sv_lane_t l);
    sv_lane_t r;
    r = l;
    if (l.rem >= l.dsr) begin
      r.rem = l.rem - l.dsr;
      r.quo = {l.quo[QuoW-2:0], 1'b1};
    end else begin
      r.quo = {l.quo[QuoW-2:0], 1'b0};
    end
    r.dsr = l.dsr >> 1;
    return r;
  endfunction

  function automatic div_word_t div_step(div_word_t w);
    div_word_t r;
    r.hue = hue_step(w.hue);
    r.sat = sv_step(w.sat);
    r.val = sv_step(w.val);
    return r;
  endfunction

endpackage

>>> design/hsv_div_cell.sv
// one divider cell: resolves one quotient bit of the hue, saturation and value lanes
`timescale 1ns / 1ps

module hsv_div_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  hsv_pkg::div_word_t in_word_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output hsv_pkg::div_word_t out_word_o
);

  logic               valid_q;
  hsv_pkg::div_word_t word_q;
  logic               adv;

  // cell may load when empty or when its word moves on
  assign adv        = !valid_q || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && adv) begin
      word_q <= hsv_pkg::div_step(in_word_i);
    end
  end

  assign out_valid_o = valid_q;
  assign out_word_o  = word_q;

endmodule

>>> design/hsv_prep.sv
// front stages: max, min, sector and hue numerator, then divider operands per mode
`timescale 1ns / 1ps

module hsv_prep (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        scale_i,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  logic [hsv_pkg::ChanW-1:0]   red_i,
  input  logic [hsv_pkg::ChanW-1:0]   green_i,
  input  logic [hsv_pkg::ChanW-1:0]   blue_i,
  output logic                        valid_o,
  input  logic                        ready_i,
  output hsv_pkg::div_word_t          word_o
);

  localparam int unsigned CW  = hsv_pkg::ChanW;
  localparam int unsigned NW  = hsv_pkg::HueNumW;
  localparam int unsigned HW  = hsv_pkg::HueDivW;
  localparam int unsigned SW  = hsv_pkg::SvDivW;
  localparam int unsigned TW  = NW + 1;
  // ceil(2^25 / 510), exact floor for dividends below 66052
  localparam int unsigned ValRecip = 65794;
  localparam int unsigned ValShift = 25;

  // stage one
  hsv_pkg::sector_e       sec;
  logic [CW-1:0]          mx, mn, d, p, q;
  logic [NW-1:0]          base, d360;
  logic signed [CW:0]     diff;
  logic signed [TW-1:0]   term, tot;

  logic                   v1_q;
  logic [NW-1:0]          num1_q;
  logic [CW-1:0]          d1_q, mx1_q;

  // stage two
  hsv_pkg::div_word_t     w_d;
  hsv_pkg::div_word_t     w_q;
  logic                   v2_q;
  logic                   rdy1, rdy2;
  logic [31:0]            vnum, vprod;

  assign rdy2    = !v2_q || ready_i;
  assign rdy1    = !v1_q || rdy2;
  assign ready_o = rdy1;

  always_comb begin
    // ties for largest go to blue, then green
    if (blue_i >= red_i && blue_i >= green_i) begin
      sec = hsv_pkg::SEC_BLUE;
      mx  = blue_i;
    end else if (green_i >= red_i && green_i >= blue_i) begin
      sec = hsv_pkg::SEC_GREEN;
      mx  = green_i;
    end else begin
      sec = hsv_pkg::SEC_RED;
      mx  = red_i;
    end
    mn = red_i;
    if (green_i < mn) mn = green_i;
    if (blue_i < mn) mn = blue_i;
    d    = mx - mn;
    d360 = NW'(d) * NW'(360);
    unique case (sec)
      hsv_pkg::SEC_GREEN: begin
        base = NW'(d) * NW'(120);
        p    = blue_i;
        q    = red_i;
      end
      hsv_pkg::SEC_BLUE: begin
        base = NW'(d) * NW'(240);
        p    = red_i;
        q    = green_i;
      end
      default: begin
        base = '0;
        p    = green_i;
        q    = blue_i;
      end
    endcase
    diff = $signed({1'b0, p}) - $signed({1'b0, q});
    term = $signed(TW'(diff)) * $signed(TW'(60));
    tot  = $signed({1'b0, base}) + term;
    // red sector wraps into 0..360
    if (tot < 0) tot = tot + $signed({1'b0, d360});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= valid_i;
      if (rdy2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && rdy1) begin
      num1_q <= tot[NW-1:0];
      d1_q   <= d;
      mx1_q  <= mx;
    end
  end

  always_comb begin
    w_d = '0;
    // percent value (200 mx + 255) / 510 by reciprocal multiply
    vnum  = 32'(mx1_q) * 32'(200) + 32'(255);
    vprod = vnum * 32'(ValRecip);
    // hue lane, gray pixel divides zero by one
    if (d1_q == '0) begin
      w_d.hue.rem = '0;
      w_d.hue.dsr = HW'(1) << hsv_pkg::DsrShift;
    end else if (scale_i) begin
      w_d.hue.rem = HW'(num1_q) * HW'(255);
      w_d.hue.dsr = (HW'(d1_q) * HW'(360)) << hsv_pkg::DsrShift;
    end else begin
      w_d.hue.rem = HW'(num1_q);
      w_d.hue.dsr = HW'(d1_q) << hsv_pkg::DsrShift;
    end
    // saturation lane, black pixel divides zero by one
    if (mx1_q == '0) begin
      w_d.sat.rem = '0;
      w_d.sat.dsr = SW'(1) << hsv_pkg::DsrShift;
    end else if (scale_i) begin
      w_d.sat.rem = SW'(d1_q) * SW'(255);
      w_d.sat.dsr = SW'(mx1_q) << hsv_pkg::DsrShift;
    end else begin
      // percent rounded half up: (200 d + mx) / (2 mx)
      w_d.sat.rem = SW'(d1_q) * SW'(200) + SW'(mx1_q);
      w_d.sat.dsr = SW'({mx1_q, 1'b0}) << hsv_pkg::DsrShift;
    end
    // value lane only passes its word through, divided by one
    w_d.val.dsr = SW'(1) << hsv_pkg::DsrShift;
    if (scale_i) begin
      w_d.val.rem = SW'(mx1_q);
    end else begin
      w_d.val.rem = SW'(vprod[31:ValShift]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (v1_q && rdy2) begin
      w_q <= w_d;
    end
  end

  assign valid_o = v2_q;
  assign word_o  = w_q;

endmodule

>>> design/rgb_to_hsv_pixel.sv
// top level of the rgb to hsv pixel converter
// Converts one 8-bit rgb pixel per word into hue, saturation and value.
// Input channel s_axis: tdata carries red, green, blue (8 bits each, red lowest).
// Output channel m_axis: tdata carries hue (9 bits), saturation (8), value (8),
// then zero padding up to 32 bits.
// cfg_we_i / cfg_wdata_i write the scale mode: 0 gives hue in degrees 0..359 and
// saturation and value in percent, 1 gives all three on the 0..255 scale.
// Write the mode only while no pixel is in flight.
// A pixel passes two front stages (channel sort and hue numerator, then operand
// setup) and a chain of nine divider cells, each resolving one quotient bit of
// the hue, saturation and value lanes. Throughput is one pixel per cycle while
// s_axis_tready is high; every stage has its own valid flag, so a stalled
// output only holds the last stage and new pixels keep entering until all
// 11 stages are full, after which s_axis_tready drops.
// Reset empties the pipeline and sets the scale mode to 0; no pixel in
// flight survives reset.
`timescale 1ns / 1ps

module rgb_to_hsv_pixel (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic                           cfg_wdata_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // red [7:0], green [15:8], blue [23:16]
  input  logic [hsv_pkg::InDataW-1:0]    s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // hue [8:0], saturation [16:9], value [24:17], zeros [31:25]
  output logic [hsv_pkg::OutDataW-1:0]   m_axis_tdata
);

  localparam int unsigned NumCells = hsv_pkg::QuoW;
  localparam int unsigned CW       = hsv_pkg::ChanW;
  localparam int unsigned PadW     = hsv_pkg::OutDataW - hsv_pkg::HueW
                                     - hsv_pkg::SatW - hsv_pkg::ValW;

  logic                scale_q;
  logic [NumCells:0]   vld;
  logic [NumCells:0]   rdy;
  hsv_pkg::div_word_t  wrd [NumCells+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= 1'b0;
    end else if (cfg_we_i) begin
      scale_q <= cfg_wdata_i;
    end
  end

  hsv_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .scale_i (scale_q),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .red_i   (s_axis_tdata[CW-1:0]),
    .green_i (s_axis_tdata[2*CW-1:CW]),
    .blue_i  (s_axis_tdata[3*CW-1:2*CW]),
    .valid_o (vld[0]),
    .ready_i (rdy[0]),
    .word_o  (wrd[0])
  );

  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    hsv_div_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (vld[k]),
      .in_ready_o  (rdy[k]),
      .in_word_i   (wrd[k]),
      .out_valid_o (vld[k+1]),
      .out_ready_i (rdy[k+1]),
      .out_word_o  (wrd[k+1])
    );
  end

  assign rdy[NumCells] = m_axis_tready;
  assign m_axis_tvalid = vld[NumCells];
  assign m_axis_tdata  = {PadW'(0),
                          wrd[NumCells].val.quo[hsv_pkg::ValW-1:0],
                          wrd[NumCells].sat.quo[hsv_pkg::SatW-1:0],
                          wrd[NumCells].hue.quo[hsv_pkg::HueW-1:0]};

endmodule

>>> design/hsv_chk.sv
// port level checks for the rgb to hsv pixel converter, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hsv_chk (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [hsv_pkg::OutDataW-1:0] m_axis_tdata
);

  logic out_stall;

  assign out_stall = m_axis_tvalid && !m_axis_tready;

  `ASSERT_ALWAYS(a_rst_empty, !rst_ni |-> !m_axis_tvalid, "output valid during reset")

  // input only stalls when the whole chain is full and the output is blocked
  `ASSERT_AT(a_stall_src, !s_axis_tready |-> m_axis_tvalid, "input stalled, output empty")

  `ASSERT_AT(a_hue_range, m_axis_tvalid |-> (m_axis_tdata[8:0] < 9'd360), "hue out of range")

  `ASSERT_AT(a_out_hold, out_stall |=> m_axis_tvalid && $stable(m_axis_tdata), "held word changed")

endmodule

bind rgb_to_hsv_pixel hsv_chk u_hsv_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
